### rtl/rotfm_pkg.sv
// ----------------------------------------------------------------------------
// rotfm_pkg: shared types and constants of the image rotation block
// Widths of the fixed-point datapath, register indexes, the configuration
// bundle, the queued work item and the result record.
// ----------------------------------------------------------------------------
package rotfm_pkg;

   localparam int DIM_W      = 13;   // frame size register width
   localparam int COORD_W    = 12;   // pixel column / row
   localparam int DELTA_W    = 14;   // signed offset from the center
   localparam int ANGLE_W    = 16;   // Q2.14 sine / cosine
   localparam int PROD_W     = DELTA_W + ANGLE_W;
   localparam int SUM_W      = 32;
   localparam int FRAC_BITS  = 14;
   localparam int TRUNC_W    = SUM_W - FRAC_BITS;
   localparam int ADDR_W     = 24;
   localparam int PIXEL_W    = 8;
   localparam int MAX_DIM    = 4096;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
   localparam logic [ANGLE_W-1:0] RESET_SINE   = ANGLE_W'(16384);
   localparam logic [ANGLE_W-1:0] RESET_COSINE = ANGLE_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_SINE         = 2'd2,
      CSR_COSINE       = 2'd3
   } csr_index_type;

   // Effective configuration as seen by the datapath.
   typedef struct packed {
      logic        [DIM_W-1:0]   width;
      logic        [DIM_W-1:0]   height;
      logic signed [ANGLE_W-1:0] sine;
      logic signed [ANGLE_W-1:0] cosine;
   } cfg_type;

   // One classified source pixel waiting for the rotation datapath.
   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic        [PIXEL_W-1:0] pixel;
      logic                      last;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ADDR_W-1:0]  address;
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } result_type;

   // A size register of zero acts as one, anything above the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/rotfm_front.sv
// ----------------------------------------------------------------------------
// rotfm_front: source position tracking
// Keeps the raster column and row counters, turns each accepted pixel into
// its offset from the frame center and flags the final pixel of the frame.
// ----------------------------------------------------------------------------
module rotfm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  rotfm_pkg::cfg_type             cfg,
   input  logic                           req_push,
   input  logic [rotfm_pkg::PIXEL_W-1:0]  req_pixel_in,
   input  logic                           queue_full,
   output logic                           queue_push,
   output rotfm_pkg::item_type            queue_item
);
   import rotfm_pkg::*;

   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] xc, yc;
   logic               accept;
   logic               row_end;
   logic               col_end;

   assign accept  = req_push && !queue_full;
   assign xc      = cfg.width[DIM_W-1:1];
   assign yc      = cfg.height[DIM_W-1:1];
   assign row_end = {1'b0, column_ff} >= (cfg.width - DIM_W'(1));
   assign col_end = {1'b0, row_ff} >= (cfg.height - DIM_W'(1));

   assign queue_push       = accept;
   assign queue_item.dx    = $signed({2'b00, column_ff}) - $signed({2'b00, xc});
   assign queue_item.dy    = $signed({2'b00, row_ff}) - $signed({2'b00, yc});
   assign queue_item.pixel = req_pixel_in;
   assign queue_item.last  = row_end && col_end;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            column_in = '0;
            row_in    = col_end ? '0 : row_ff + COORD_W'(1);
         end else begin
            column_in = column_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

### rtl/rotfm_queue.sv
// ----------------------------------------------------------------------------
// rotfm_queue: work queue between position tracking and the datapath
// Four-entry FIFO of classified pixels.
// ----------------------------------------------------------------------------
module rotfm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rotfm_pkg::item_type push_item,
   output logic                full,
   output logic                valid,
   output rotfm_pkg::item_type head_item,
   input  logic                pop
);
   import rotfm_pkg::*;

   item_type   mem [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = count_ff == 3'd4;
   assign valid     = count_ff != 3'd0;
   assign head_item = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, do_push} - {2'b00, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("work queue count out of range");
   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> (count_ff == 3'd4)) else $error("full queue lost an entry");
`endif

endmodule

### rtl/rotfm_back.sv
// ----------------------------------------------------------------------------
// rotfm_back: rotation datapath and result buffer
// Three register stages (products, sums, truncation and range check), then
// the address multiply-add straight into an eight-entry result FIFO.
// ----------------------------------------------------------------------------
module rotfm_back (
   input  logic                clock,
   input  logic                reset,
   input  rotfm_pkg::cfg_type  cfg,
   input  logic                queue_valid,
   input  rotfm_pkg::item_type queue_item,
   output logic                queue_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rotfm_pkg::result_type rsp_result
);
   import rotfm_pkg::*;

   // Stage 1: products.
   logic                       v1_ff, v1_in;
   logic signed [PROD_W-1:0]   pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic        [PIXEL_W-1:0]  pix1_ff;
   logic                       last1_ff;
   // Stage 2: sums with the center added back.
   logic                       v2_ff;
   logic signed [SUM_W-1:0]    sx_ff, sy_ff, sx_in, sy_in;
   logic        [PIXEL_W-1:0]  pix2_ff;
   logic                       last2_ff;
   // Stage 3: truncated target and range check.
   logic                       v3_ff;
   logic                       hit3_ff, hit3_in;
   logic        [COORD_W-1:0]  x3_ff, y3_ff;
   logic        [PIXEL_W-1:0]  pix3_ff;
   logic                       last3_ff;

   logic signed [SUM_W-1:0]    xc_term, yc_term, tsx, tsy;
   logic        [TRUNC_W-1:0]  tx, ty;
   logic        [COORD_W+DIM_W-1:0] addr_full;

   // Result FIFO.
   result_type  mem [8];
   logic [2:0]  wr_ptr_ff, rd_ptr_ff;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  in_flight;
   logic        fifo_push, fifo_pop;
   result_type  wr_result;

   // Issue only when the FIFO has room for everything already in flight.
   assign in_flight = {3'b000, v1_ff} + {3'b000, v2_ff} + {3'b000, v3_ff};
   assign v1_in     = queue_valid && ((count_ff + in_flight) < 4'd8);
   assign queue_pop = v1_in;

   assign xc_term = $signed({6'd0, cfg.width[DIM_W-1:1], {FRAC_BITS{1'b0}}});
   assign yc_term = $signed({6'd0, cfg.height[DIM_W-1:1], {FRAC_BITS{1'b0}}});
   assign sx_in   = SUM_W'(pxc_ff) - SUM_W'(pys_ff) + xc_term;
   assign sy_in   = SUM_W'(pxs_ff) + SUM_W'(pyc_ff) + yc_term;

   // Truncation toward zero: bias negative sums before the arithmetic shift.
   assign tsx = sx_ff + (sx_ff[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
   assign tsy = sy_ff + (sy_ff[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
   assign tx  = tsx[SUM_W-1:FRAC_BITS];
   assign ty  = tsy[SUM_W-1:FRAC_BITS];
   assign hit3_in = !tx[TRUNC_W-1] && !ty[TRUNC_W-1]
                 && (tx < TRUNC_W'(cfg.width)) && (ty < TRUNC_W'(cfg.height));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pxc_ff   <= queue_item.dx * cfg.cosine;
      pys_ff   <= queue_item.dy * cfg.sine;
      pxs_ff   <= queue_item.dx * cfg.sine;
      pyc_ff   <= queue_item.dy * cfg.cosine;
      pix1_ff  <= queue_item.pixel;
      last1_ff <= queue_item.last;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      pix2_ff  <= pix1_ff;
      last2_ff <= last1_ff;
      hit3_ff  <= hit3_in;
      x3_ff    <= tx[COORD_W-1:0];
      y3_ff    <= ty[COORD_W-1:0];
      pix3_ff  <= pix2_ff;
      last3_ff <= last2_ff;
   end

   assign addr_full = (COORD_W+DIM_W)'(y3_ff) * (COORD_W+DIM_W)'(cfg.width)
                    + (COORD_W+DIM_W)'(x3_ff);

   assign wr_result.x       = x3_ff;
   assign wr_result.y       = y3_ff;
   assign wr_result.address = addr_full[ADDR_W-1:0];
   assign wr_result.pixel   = pix3_ff;
   assign wr_result.last    = last3_ff;

   assign fifo_push  = v3_ff && hit3_ff;
   assign rsp_empty  = count_ff == 4'd0;
   assign fifo_pop   = rsp_pop && !rsp_empty;
   assign rsp_result = mem[rd_ptr_ff];
   assign count_in   = count_ff + {3'b000, fifo_push} - {3'b000, fifo_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + 3'd1;
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 3'd1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         mem[wr_ptr_ff] <= wr_result;
      end
   end

`ifndef NO_ASSERTIONS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff + in_flight) <= 4'd8) else $error("result FIFO overcommitted");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (count_ff != 4'd8)) else $error("write into full result FIFO");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 4'd0 && count_ff != 4'd8) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result FIFO pointers disagree with count");
`endif

endmodule

### rtl/image_rotate_forward_map_top.sv
// ----------------------------------------------------------------------------
// image_rotate_forward_map_top: nearest-neighbor image rotation about center
// Forward-maps raster-order grey pixels through a Q2.14 rotation about the
// frame center and emits one destination write for each pixel that lands
// inside the frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_push / req_full   req_pixel_in
//   rsp_      out        rsp_pop / rsp_empty   target x, y, address, pixel, last
//   csr_      in         csr_valid / csr_ready csr_index, csr_data
//
// A pixel is accepted in every cycle while the four-entry work queue has
// room, so the sustained rate is one pixel per clock. An accepted
// transaction passes through the work queue and then the three datapath
// stages, after which a result that lands inside the frame is written into
// the result FIFO that feeds the rsp_ ports. The datapath issues only
// while the eight-entry result FIFO has room for every transaction in
// flight, so a stalled consumer backs up into the queue and then raises
// req_full. Synchronous reset restores the register defaults and returns the
// raster position to the top-left pixel.
//
module image_rotate_forward_map_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel input
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [rotfm_pkg::PIXEL_W-1:0]        req_pixel_in,
   // Write results
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [rotfm_pkg::COORD_W-1:0]        rsp_target_x,
   output logic [rotfm_pkg::COORD_W-1:0]        rsp_target_y,
   output logic [rotfm_pkg::ADDR_W-1:0]         rsp_target_address,
   output logic [rotfm_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                 rsp_frame_last,
   // Configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rotfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rotfm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rotfm_pkg::*;

   // Raw register contents; the size registers are clamped before use.
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [ANGLE_W-1:0] sine_ff, sine_in;
   logic [ANGLE_W-1:0] cosine_ff, cosine_in;
   logic               csr_write;

   cfg_type    cfg;
   item_type   front_item;
   item_type   head_item;
   result_type rsp_result;
   logic       queue_push;
   logic       queue_full;
   logic       queue_valid;
   logic       queue_pop;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      sine_in   = sine_ff;
      cosine_in = cosine_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = csr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_data[DIM_W-1:0];
            CSR_SINE:         sine_in   = csr_data;
            CSR_COSINE:       cosine_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         sine_ff   <= RESET_SINE;
         cosine_ff <= RESET_COSINE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   // Zero sizes act as one and oversize values as the maximum dimension.
   assign cfg.width  = eff_dim(width_ff);
   assign cfg.height = eff_dim(height_ff);
   assign cfg.sine   = $signed(sine_ff);
   assign cfg.cosine = $signed(cosine_ff);

   assign req_full = queue_full;

   rotfm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_push     (req_push),
      .req_pixel_in (req_pixel_in),
      .queue_full   (queue_full),
      .queue_push   (queue_push),
      .queue_item   (front_item)
   );

   rotfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .valid     (queue_valid),
      .head_item (head_item),
      .pop       (queue_pop)
   );

   rotfm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_valid (queue_valid),
      .queue_item  (head_item),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_result  (rsp_result)
   );

   assign rsp_target_x       = rsp_result.x;
   assign rsp_target_y       = rsp_result.y;
   assign rsp_target_address = rsp_result.address;
   assign rsp_pixel_out      = rsp_result.pixel;
   assign rsp_frame_last     = rsp_result.last;

endmodule
